### rtl/core/crc32_frame_receiver_top_assert.svh
// Assertion macros shared by the frame receiver modules.
`ifndef CRC32_FRAME_RECEIVER_TOP_ASSERT_SVH
`define CRC32_FRAME_RECEIVER_TOP_ASSERT_SVH
`ifndef SYNTH
`define CRCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CRCFR_NEVER(lbl, cond, msg) \
  `CRCFR_ASSERT(lbl, !(cond), msg)
`else
`define CRCFR_ASSERT(lbl, prop, msg)
`define CRCFR_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/crcfr_pkg.sv
// Types, constants and the CRC-32 byte update shared by the frame receiver.
package crcfr_pkg;

  localparam int unsigned MAX_FRAME  = 512;
  localparam int unsigned ADDR_W     = $clog2(MAX_FRAME);
  localparam int unsigned LEN_W      = $clog2(MAX_FRAME + 1);
  localparam int unsigned HEAD_BYTES = 4;
  localparam int unsigned MIN_FRAME  = 8;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [7:0]  SYNC_RESET = 8'h5A;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;

  // Queue entry: one classified transaction.
  typedef struct packed {
    logic              is_read;
    logic              rd_ok;
    logic [7:0]        rx_byte;
    logic [ADDR_W-1:0] addr;
  } item_t;

  // Fields of a pending result held in the output register.
  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic [7:0] ptype;
    logic [8:0] plen;
    logic       rd_ok;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/crcfr_in_if.sv
// Input channel: command, received byte and read position.
interface crcfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic [8:0] read_index;

  modport source (output valid, command, rx_byte, read_index, input ready);
  modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

### rtl/core/crcfr_out_if.sv
// Output channel: frame report or read data.
interface crcfr_out_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic [1:0] frame_status;
  logic [7:0] packet_type;
  logic [8:0] payload_length;
  logic [7:0] read_data;

  modport source (output valid, frame_done, frame_status, packet_type, payload_length,
                  read_data, input ready);
  modport sink   (input valid, frame_done, frame_status, packet_type, payload_length,
                  read_data, output ready);
endinterface

### rtl/core/crcfr_front.sv
// Front end: accept transactions and classify them for the queue.
module crcfr_front
  import crcfr_pkg::*;
(
  crcfr_in_if.sink in_i,
  input  logic     full_i,
  output logic     push_o,
  output item_t    item_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.is_read = (in_i.command == CMD_READ);
    item_o.rd_ok   = (17'(in_i.read_index) < 17'(MAX_FRAME));
    item_o.rx_byte = in_i.rx_byte;
    item_o.addr    = ADDR_W'(in_i.read_index);
  end

endmodule

### rtl/core/crcfr_queue.sv
// Two-entry queue between the front end and the frame engine.
module crcfr_queue
  import crcfr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output item_t head_o
);

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= item_i;
  end

  `include "crc32_frame_receiver_top_assert.svh"
  `CRCFR_NEVER(a_q_no_overflow, push_i && full_o, "push into full queue")
  `CRCFR_NEVER(a_q_no_underflow, pop_i && !head_valid_o, "pop from empty queue")
  `CRCFR_ASSERT(a_q_cnt_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 2'd1), "push lost")

endmodule

### rtl/core/crcfr_back.sv
// Frame engine: sync hunt, header parse, CRC, payload store and output register.
module crcfr_back
  import crcfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] sync_byte_i,
  input  logic       head_valid_i,
  input  item_t      head_i,
  output logic       pop_o,
  crcfr_out_if.source out_o
);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_LEN_LO  = 6'b000010,
    PH_LEN_HI  = 6'b000100,
    PH_TYPE    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CRC     = 6'b100000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [7:0]         len_lo_q, len_lo_d;
  logic [31:0]        crc_q, crc_d;
  logic [23:0]        crc_rx_q, crc_rx_d;
  logic [7:0]         type_q, type_d;

  logic               out_vld_q;
  result_t            res_q, res_d;
  logic               emit;
  logic [7:0]         rdata_q;
  logic [7:0]         mem [MAX_FRAME];

  logic               byte_pop, rd_pop, mem_we;
  logic [7:0]         b;
  logic [15:0]        len16;
  logic [LEN_W-1:0]   len_m4, cnt_inc;
  logic [1:0]         crc_k;
  logic [ADDR_W-1:0]  wr_addr;
  logic [31:0]        crc_fin;

  assign pop_o    = head_valid_i && (!out_vld_q || out_o.ready);
  assign byte_pop = pop_o && !head_i.is_read;
  assign rd_pop   = pop_o && head_i.is_read;
  assign b        = head_i.rx_byte;
  assign len16    = {b, len_lo_q};
  assign len_m4   = len_q - LEN_W'(HEAD_BYTES);
  assign cnt_inc  = cnt_q + LEN_W'(1);
  assign crc_k    = 2'(cnt_q - len_m4);
  assign wr_addr  = ADDR_W'(cnt_q - LEN_W'(HEAD_BYTES));
  assign crc_fin  = {b, crc_rx_q} ^ CRC_INIT;
  assign mem_we   = byte_pop && (phase_q == PH_PAYLOAD);

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    len_lo_d = len_lo_q;
    crc_d    = crc_q;
    crc_rx_d = crc_rx_q;
    type_d   = type_q;
    emit     = rd_pop;
    res_d    = '0;
    res_d.rd_ok = head_i.rd_ok;
    if (byte_pop) begin
      case (phase_q)
        PH_HUNT: begin
          if (b == sync_byte_i) begin
            crc_d   = crc_byte(CRC_INIT, b);
            cnt_d   = LEN_W'(1);
            phase_d = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          len_lo_d = b;
          crc_d    = crc_byte(crc_q, b);
          cnt_d    = LEN_W'(2);
          phase_d  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (len16 < 16'(MIN_FRAME) || len16 > 16'(MAX_FRAME)) begin
            // bad length: report and drop straight back to hunting
            emit         = 1'b1;
            res_d.done   = 1'b1;
            res_d.status = ST_BAD_LEN;
            crc_d        = CRC_INIT;
            cnt_d        = '0;
            phase_d      = PH_HUNT;
          end else begin
            len_d   = LEN_W'(len16);
            crc_d   = crc_byte(crc_q, b);
            cnt_d   = LEN_W'(3);
            phase_d = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_d  = b;
          crc_d   = crc_byte(crc_q, b);
          cnt_d   = LEN_W'(HEAD_BYTES);
          phase_d = (len_q > LEN_W'(MIN_FRAME)) ? PH_PAYLOAD : PH_CRC;
        end
        PH_PAYLOAD: begin
          crc_d = crc_byte(crc_q, b);
          cnt_d = cnt_inc;
          if (cnt_inc >= len_m4) phase_d = PH_CRC;
        end
        PH_CRC: begin
          cnt_d = cnt_inc;
          case (crc_k)
            2'd0:    crc_rx_d[7:0]   = b;
            2'd1:    crc_rx_d[15:8]  = b;
            2'd2:    crc_rx_d[23:16] = b;
            default: begin
              emit         = 1'b1;
              res_d.done   = 1'b1;
              res_d.status = (crc_fin == crc_q) ? ST_GOOD : ST_CRC_ERR;
              res_d.ptype  = type_q;
              res_d.plen   = 9'(len_q - LEN_W'(MIN_FRAME));
              crc_d        = CRC_INIT;
              cnt_d        = '0;
              phase_d      = PH_HUNT;
            end
          endcase
        end
        default: begin
          crc_d   = CRC_INIT;
          cnt_d   = '0;
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      cnt_q     <= '0;
      len_q     <= '0;
      len_lo_q  <= '0;
      crc_q     <= CRC_INIT;
      crc_rx_q  <= '0;
      type_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      len_lo_q <= len_lo_d;
      crc_q    <= crc_d;
      crc_rx_q <= crc_rx_d;
      type_q   <= type_d;
      if (pop_o) begin
        out_vld_q <= emit;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  // payload store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= b;
    if (rd_pop) rdata_q <= mem[head_i.addr];
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.frame_done     = res_q.done;
  assign out_o.frame_status   = res_q.status;
  assign out_o.packet_type    = res_q.ptype;
  assign out_o.payload_length = res_q.plen;
  assign out_o.read_data      = (!res_q.done && res_q.rd_ok) ? rdata_q : 8'd0;

  `include "crc32_frame_receiver_top_assert.svh"
  `CRCFR_ASSERT(a_hunt_after_end, (byte_pop && emit) |=> (phase_q == PH_HUNT), "not hunting")
  `CRCFR_NEVER(a_we_in_payload, mem_we && phase_q != PH_PAYLOAD, "stray write")

endmodule

### rtl/core/crc32_frame_receiver_top.sv
// Top level of the CRC-32 frame receiver: front end, queue, frame engine, sync register.
//
// The receiver takes one transaction per cycle on in_i while the queue has
// room. A byte transaction (command 0) feeds the deframer: it hunts for the
// sync byte, reads a little-endian 16-bit total length and a type byte,
// stores the payload (length - 8 bytes) and checks a trailing little-endian
// CRC-32 (reflected, polynomial 0xEDB88320, init and final XOR all ones)
// taken over every byte from sync to the last payload byte. At the last CRC
// byte one report comes out with frame_done set: status good or CRC mismatch,
// the type byte and the payload length. A length under 8 or over 512 is
// reported at once with status bad length and hunting resumes with the next
// byte. A read transaction (command 1) returns one stored payload byte; a
// read of a position never written returns an arbitrary value. While
// out_o.ready stays high, the sustained rate is one transaction per clock,
// set by the byte-wide CRC update and the single-port payload memory, which
// take one write or one read each cycle. A result passes through the
// two-entry queue and then the output register before it is offered on
// out_o. The output register holds a result while out_o.ready is low; the
// queue keeps taking transactions until it fills. The payload store needs no
// clearing pass, so the block is ready straight after reset. Write the sync
// byte (reset 0x5A) only while the block is idle.
module crc32_frame_receiver_top
  import crcfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  crcfr_in_if.sink    in_i,
  crcfr_out_if.source out_o
);

  logic [7:0] sync_q;
  logic       push, full, pop, head_valid;
  item_t      item, head;

  // sync byte register: plain write, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else if (cfg_we_i) begin
      sync_q <= cfg_wdata_i;
    end
  end

  // accept and classify each transaction
  crcfr_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (item)
  );

  // decouple the front end from the frame engine
  crcfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // advance the deframer and drive the registered result
  crcfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sync_byte_i  (sync_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
